// ----- hw/rtl/firlp_pkg.sv -----
package firlp_pkg;

  // number of nonzero coefficients, one mac step each
  localparam int unsigned NCOEF = 16;
  localparam int unsigned TAP_W = 4;

  localparam int unsigned SAMP_W = 16;
  localparam int unsigned COEF_W = 14;
  localparam int unsigned PROD_W = SAMP_W + COEF_W;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned FRAC_BITS = 15;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 32'sd16384;
  localparam logic signed [ACC_W-1:0] SAT_MAX    = 32'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_MIN    = -32'sd32768;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_FIN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic             load;  // take new word, start a pass
    logic             rd;    // read one delay-line entry
    logic             mac;   // accumulate the entry read last cycle
    logic             fin;   // round, saturate, load output, advance pointer
    logic [TAP_W-1:0] tap;   // tap index of the read
  } cmd_t;

  // symmetric low-pass coefficients, Q15
  function automatic logic signed [COEF_W-1:0] coef(input logic [TAP_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    case (k)
      4'd0, 4'd15: c = 14'sd279;
      4'd1, 4'd14: c = 14'sd436;
      4'd2, 4'd13: c = 14'sd875;
      4'd3, 4'd12: c = 14'sd1544;
      4'd4, 4'd11: c = 14'sd2336;
      4'd5, 4'd10: c = 14'sd3113;
      4'd6, 4'd9:  c = 14'sd3730;
      4'd7, 4'd8:  c = 14'sd4071;
      default:     c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/firlp_ctrl.sv -----
module firlp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output firlp_pkg::cmd_t   cmd
);

  firlp_pkg::state_t             state_r, state_nxt;
  logic [firlp_pkg::TAP_W-1:0]   cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          can_fin;

  // state, tap counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= firlp_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign can_fin = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.tap   = cnt_r;
    case (state_r)
      firlp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = firlp_pkg::S_MAC;
        end
      end
      firlp_pkg::S_MAC: begin
        cmd.rd  = 1'b1;
        cmd.mac = (cnt_r != '0);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == firlp_pkg::TAP_W'(firlp_pkg::NCOEF - 1)) begin
          state_nxt = firlp_pkg::S_DRAIN;
        end
      end
      firlp_pkg::S_DRAIN: begin
        cmd.mac   = 1'b1;
        state_nxt = firlp_pkg::S_FIN;
      end
      firlp_pkg::S_FIN: begin
        if (can_fin) begin
          cmd.fin   = 1'b1;
          state_nxt = firlp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = firlp_pkg::S_IDLE;
      end
    endcase
  end

  // output word held until taken
  always_comb begin
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/firlp_dp.sv -----
module firlp_dp #(
  parameter int unsigned TAPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  firlp_pkg::cmd_t         cmd,
  input  logic signed [15:0]      sample_in,
  output logic signed [15:0]      sample_out
);

  localparam int unsigned PTR_W = $clog2(TAPS);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPS - 1);

  // delay line, valid bits stand in for the zero reset
  logic signed [15:0]              mem [TAPS];
  logic [TAPS-1:0]                 vld_r;
  logic [PTR_W-1:0]                wp_r;
  logic [PTR_W-1:0]                rp_r;
  logic signed [15:0]              rd_data_r;
  logic                            rd_vld_r;
  logic [firlp_pkg::TAP_W-1:0]     tap_d_r;
  logic signed [firlp_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [15:0]              out_r;

  logic signed [15:0]                  samp;
  logic signed [firlp_pkg::COEF_W-1:0] c;
  logic signed [firlp_pkg::PROD_W-1:0] prod;
  logic signed [firlp_pkg::ACC_W-1:0]  biased;
  logic signed [firlp_pkg::ACC_W-1:0]  shifted;
  logic signed [15:0]                  sat;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wp_r] <= sample_in;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rp_r];
    end
  end

  // valid bits, pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      wp_r     <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        vld_r[wp_r] <= 1'b1;
      end
      if (cmd.rd) begin
        rd_vld_r <= vld_r[rp_r];
      end
      if (cmd.fin) begin
        wp_r <= (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
      end
    end
  end

  // read pointer walks back from the newest word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rp_r <= wp_r;
    end else if (cmd.rd) begin
      rp_r <= (rp_r == '0) ? PTR_LAST : rp_r - 1'b1;
    end
    if (cmd.rd) begin
      tap_d_r <= cmd.tap;
    end
  end

  // multiply-accumulate
  assign samp = rd_vld_r ? rd_data_r : '0;
  assign c    = firlp_pkg::coef(tap_d_r);
  assign prod = c * samp;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load) begin
      acc_nxt = '0;
    end else if (cmd.mac) begin
      acc_nxt = acc_r + firlp_pkg::ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // round half up, floor shift, saturate
  assign biased  = acc_r + firlp_pkg::ROUND_HALF;
  assign shifted = biased >>> firlp_pkg::FRAC_BITS;

  always_comb begin
    if (shifted > firlp_pkg::SAT_MAX) begin
      sat = 16'sh7fff;
    end else if (shifted < firlp_pkg::SAT_MIN) begin
      sat = 16'sh8000;
    end else begin
      sat = shifted[15:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r <= sat;
    end
  end

  assign sample_out = out_r;

endmodule

// ----- hw/rtl/fir_lowpass_16tap_top.sv -----
// channel  | ports                              | word
// input    | in_valid, in_ready, in_sample_in   | one Q15 sample
// result   | out_valid, out_ready, out_sample_out | one filtered Q15 sample
//
// the word is written into the delay line at its accept edge; 16 steps of the single
// shared multiply-accumulate, one drain step and one round/saturate step follow, and
// the result is then valid; a new word is taken only after that whole pass has ended.
// reset (rst_n, synchronous) clears the delay-line valid bits, so the line reads as zero.
// a waiting result does not block the next word; the block holds in the
// final step only while the output register is full and out_ready is low.
module fir_lowpass_16tap_top #(
  parameter int unsigned TAPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_out
);

  firlp_pkg::cmd_t cmd;

  // sequencer
  firlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // delay line and mac
  firlp_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample_in  (in_sample_in),
    .sample_out (out_sample_out)
  );

endmodule
